// ===== rtl/core/cab_pkg.sv =====
// cab_pkg: shared constants, codes and types of the clipped alpha blitter
// no dependencies; imported by the top level and the testbench
package cab_pkg;

  // destination geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int FB_AW      = $clog2(FB_DEPTH);
  localparam int FB_DW      = 32;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // signed position width: source counter plus 8-bit offset, with headroom
  localparam int POS_BASE_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int POS_W      = ((POS_BASE_W > 8) ? POS_BASE_W : 8) + 2;

  // stream field widths
  localparam int FB_ADDR_W  = 12;
  localparam int CHAN_W     = 8;
  localparam int POS_OUT_W  = 6;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // address wrap: subtract steps of the depth that fit in a 12-bit address
  localparam int WRAP_STEPS = (FB_DEPTH > 4095) ? 0 : $clog2((4095 / FB_DEPTH) + 1);

  // configuration register indexes
  localparam logic [2:0] CFG_DEST_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_DEST_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_SPRITE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_SPRITE_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_OFFSET_X      = 3'd4;
  localparam logic [2:0] CFG_OFFSET_Y      = 3'd5;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_READ = 2'd1,
    CMD_BLIT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_READ    = 3'd1,
    ST_CLIPPED = 3'd2,
    ST_SKIPPED = 3'd3,
    ST_WRITTEN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_RDATA,
    S_MUL,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// ===== rtl/core/cab_ram.sv =====
// cab_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module cab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/clipped_alpha_blit_core.sv =====
// clipped_alpha_blit_core: top level of the clipped alpha blitter
// depends on cab_pkg and cab_ram
//
// usage: the slave stream carries commands in tuser (load word, read word,
// blit pixel) with address and rgba in tdata; the master stream returns one
// result beat per command with its status in tuser and the final sprite
// pixel marked on tlast. configuration is a plain write port (index, data),
// to be written only while the block is idle, a rule the block leaves unchecked.
// after reset the framebuffer is swept to zero, one word a cycle, over all
// FB_DEPTH (4096) words; s_axis_tready stays low during the sweep.
// one command is in flight at a time; after accept, every command passes the
// look-up step and then the output step; a read adds a read-data step, and a
// blend adds the framebuffer read-modify-write between them (registered read,
// multiply stage, divide-by-255 stage).
// a result waiting on a stalled receiver sits in the output register; the
// next command is accepted and worked on, and holds in its last step until
// the output register frees up.
module clipped_alpha_blit_core
  import cab_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  // command stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // fields from bit 0: fb_addr[11:0], red, green, blue, alpha, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // fields from bit 0: cmd[1:0]
  input  logic [1:0]            s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fields from bit 0: out_red, out_green, out_blue, out_alpha,
  // dest_col[5:0], dest_row[5:0], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // fields from bit 0: status[2:0]
  output logic [2:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  // address wrap modulo the framebuffer depth
  function automatic logic [FB_AW-1:0] wrap_addr(logic [FB_ADDR_W-1:0] a);
    logic [FB_ADDR_W-1:0] v;
    v = a;
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      if (v >= FB_ADDR_W'(FB_DEPTH << k)) begin
        v = v - FB_ADDR_W'(FB_DEPTH << k);
      end
    end
    return FB_AW'(v);
  endfunction

  // floor(x / 255) for x below 65535, by reciprocal multiply with 257
  function automatic logic [CHAN_W-1:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1;
    return CHAN_W'((t + (t >> 8)) >> 8);
  endfunction

  // configuration registers
  logic [6:0]        dest_width_q, dest_height_q, sprite_width_q, sprite_height_q;
  logic signed [7:0] offset_x_q, offset_y_q;

  // control state
  state_e           state_q, state_d;
  logic [FB_AW-1:0] clr_addr_q, clr_addr_d;
  logic [COL_W-1:0] src_col_q, src_col_d;
  logic [ROW_W-1:0] src_row_q, src_row_d;
  logic             out_valid_q, out_valid_d;

  // captured command
  cmd_e                 cmd_q;
  logic [FB_ADDR_W-1:0] addr_q;
  logic [CHAN_W-1:0]    red_q, green_q, blue_q, alpha_q;

  // blend datapath
  logic [FB_AW-1:0]     idx_q, idx_d;
  logic [15:0]          prod_q [3];
  logic [15:0]          prod_d [3];

  // pending result
  status_e              res_status_q, res_status_d;
  logic [FB_DW-1:0]     res_word_q, res_word_d;
  logic [POS_OUT_W-1:0] res_col_q, res_col_d, res_row_q, res_row_d;
  logic                 res_last_q, res_last_d;

  // output register
  status_e              out_status_q;
  logic [FB_DW-1:0]     out_word_q;
  logic [POS_OUT_W-1:0] out_col_q, out_row_q;
  logic                 out_last_q;

  // memory port
  logic             ram_we;
  logic [FB_AW-1:0] ram_waddr, ram_raddr;
  logic [FB_DW-1:0] ram_wdata, ram_rdata;

  // blit geometry
  logic signed [POS_W-1:0] dx, dy;
  logic [POS_W-1:0]        dw_eff, dh_eff;
  logic [COL_W:0]          sw_eff, col_inc;
  logic [ROW_W:0]          sh_eff, row_inc;
  logic                    row_end, last_px, clipped;
  logic [FB_AW-1:0]        blit_idx;

  logic in_accept;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_width_q    <= 7'd64;
      dest_height_q   <= 7'd64;
      sprite_width_q  <= 7'd64;
      sprite_height_q <= 7'd64;
      offset_x_q      <= '0;
      offset_y_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEST_WIDTH:    dest_width_q    <= cfg_wdata_i[6:0];
        CFG_DEST_HEIGHT:   dest_height_q   <= cfg_wdata_i[6:0];
        CFG_SPRITE_WIDTH:  sprite_width_q  <= cfg_wdata_i[6:0];
        CFG_SPRITE_HEIGHT: sprite_height_q <= cfg_wdata_i[6:0];
        CFG_OFFSET_X:      offset_x_q      <= $signed(cfg_wdata_i);
        CFG_OFFSET_Y:      offset_y_q      <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // destination position, clip test and source counter step
  always_comb begin
    dx = POS_W'($signed({1'b0, src_col_q})) + POS_W'(offset_x_q);
    dy = POS_W'($signed({1'b0, src_row_q})) + POS_W'(offset_y_q);
    dw_eff = (int'(dest_width_q) > MAX_WIDTH) ? POS_W'(MAX_WIDTH) : POS_W'(dest_width_q);
    dh_eff = (int'(dest_height_q) > MAX_HEIGHT) ? POS_W'(MAX_HEIGHT)
                                                : POS_W'(dest_height_q);
    sw_eff = (sprite_width_q == '0) ? (COL_W+1)'(1) :
             (int'(sprite_width_q) > MAX_WIDTH) ? (COL_W+1)'(MAX_WIDTH)
                                                : (COL_W+1)'(sprite_width_q);
    sh_eff = (sprite_height_q == '0) ? (ROW_W+1)'(1) :
             (int'(sprite_height_q) > MAX_HEIGHT) ? (ROW_W+1)'(MAX_HEIGHT)
                                                  : (ROW_W+1)'(sprite_height_q);
    col_inc  = {1'b0, src_col_q} + (COL_W+1)'(1);
    row_inc  = {1'b0, src_row_q} + (ROW_W+1)'(1);
    row_end  = (col_inc >= sw_eff);
    last_px  = row_end && (row_inc >= sh_eff);
    clipped  = dx[POS_W-1] || dy[POS_W-1] ||
               ($unsigned(dx) >= dw_eff) || ($unsigned(dy) >= dh_eff);
    // row and column taken as unsigned bits of the in-range position
    blit_idx = FB_AW'(FB_AW'(dy[ROW_W-1:0]) * FB_AW'(MAX_WIDTH) +
                      FB_AW'(dx[COL_W-1:0]));
  end

  // sequencer: clear sweep, command capture, read-modify-write, result hand-off
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    src_col_d    = src_col_q;
    src_row_d    = src_row_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    idx_d        = idx_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_word_d   = res_word_q;
    res_col_d    = res_col_q;
    res_row_d    = res_row_q;
    res_last_d   = res_last_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + FB_AW'(1);
        if (clr_addr_q == FB_AW'(FB_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        res_word_d = '0;
        res_col_d  = '0;
        res_row_d  = '0;
        res_last_d = 1'b0;
        state_d    = S_OUT;
        unique case (cmd_q)
          CMD_LOAD: begin
            ram_we       = 1'b1;
            ram_waddr    = wrap_addr(addr_q);
            ram_wdata    = {alpha_q, blue_q, green_q, red_q};
            res_status_d = ST_LOADED;
          end
          CMD_BLIT: begin
            res_last_d = last_px;
            // source counters advance for every blit beat
            if (row_end) begin
              src_col_d = '0;
              src_row_d = (row_inc >= sh_eff) ? '0 : ROW_W'(row_inc);
            end else begin
              src_col_d = COL_W'(col_inc);
            end
            priority if (clipped) begin
              res_status_d = ST_CLIPPED;
            end else if (alpha_q == '0) begin
              res_status_d = ST_SKIPPED;
            end else begin
              res_col_d = POS_OUT_W'(dx);
              res_row_d = POS_OUT_W'(dy);
              idx_d     = blit_idx;
              if (alpha_q == ALPHA_OPAQUE) begin
                ram_we       = 1'b1;
                ram_waddr    = blit_idx;
                ram_wdata    = {ALPHA_OPAQUE, blue_q, green_q, red_q};
                res_status_d = ST_WRITTEN;
                res_word_d   = {ALPHA_OPAQUE, blue_q, green_q, red_q};
              end else begin
                ram_raddr = blit_idx;
                state_d   = S_MUL;
              end
            end
          end
          default: begin
            // read word, and the unused command code behaves the same
            ram_raddr = wrap_addr(addr_q);
            state_d   = S_RDATA;
          end
        endcase
      end

      S_RDATA: begin
        res_status_d = ST_READ;
        res_word_d   = ram_rdata;
        state_d      = S_OUT;
      end

      S_MUL: begin
        // s*a + d*(255-a) per color channel
        prod_d[0] = 16'(red_q) * 16'(alpha_q) +
                    16'(ram_rdata[7:0]) * 16'(ALPHA_OPAQUE - alpha_q);
        prod_d[1] = 16'(green_q) * 16'(alpha_q) +
                    16'(ram_rdata[15:8]) * 16'(ALPHA_OPAQUE - alpha_q);
        prod_d[2] = 16'(blue_q) * 16'(alpha_q) +
                    16'(ram_rdata[23:16]) * 16'(ALPHA_OPAQUE - alpha_q);
        state_d   = S_DIV;
      end

      S_DIV: begin
        ram_we       = 1'b1;
        ram_waddr    = idx_q;
        ram_wdata    = {ALPHA_OPAQUE, div255(prod_q[2]), div255(prod_q[1]),
                        div255(prod_q[0])};
        res_status_d = ST_WRITTEN;
        res_word_d   = ram_wdata;
        state_d      = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      addr_q  <= s_axis_tdata[11:0];
      red_q   <= s_axis_tdata[19:12];
      green_q <= s_axis_tdata[27:20];
      blue_q  <= s_axis_tdata[35:28];
      alpha_q <= s_axis_tdata[43:36];
    end
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_word_q   <= res_word_d;
    res_col_q    <= res_col_d;
    res_row_q    <= res_row_d;
    res_last_q   <= res_last_d;
    if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
      out_status_q <= res_status_q;
      out_word_q   <= res_word_q;
      out_col_q    <= res_col_q;
      out_row_q    <= res_row_q;
      out_last_q   <= res_last_q;
    end
  end

  // framebuffer
  cab_ram #(
    .WIDTH (FB_DW),
    .DEPTH (FB_DEPTH)
  ) u_fb (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_row_q, out_col_q, out_word_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted while another is in flight");

  a_written_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_WRITTEN)) |-> (m_axis_tdata[31:24] == ALPHA_OPAQUE))
    else $error("written pixel without opaque alpha");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_LOOK || state_q == S_DIV))
    else $error("framebuffer write outside clear, load, copy or blend");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !m_axis_tvalid)
    else $error("result issued during clear sweep");

endmodule

// ===== sim/tb_clipped_alpha_blit_core.sv =====
// tb_clipped_alpha_blit_core: self-checking testbench of the clipped alpha blitter
// holds a framebuffer predictor with its own result scoreboard, and stream drivers
// depends on cab_pkg and clipped_alpha_blit_core
`timescale 1ns / 100ps

typedef struct packed {
  logic [2:0] status;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [5:0] col;
  logic [5:0] row;
  logic       last;
} blit_beat_t;

// framebuffer and sprite position predictor, compares result beats in order
class blit_checker;
  logic [31:0] fb_model [cab_pkg::FB_DEPTH];
  int unsigned src_x;
  int unsigned src_y;
  logic [6:0]  dst_w;
  logic [6:0]  dst_h;
  logic [6:0]  spr_w;
  logic [6:0]  spr_h;
  logic [7:0]  ofs_x;
  logic [7:0]  ofs_y;
  blit_beat_t  pending_beats [$];
  int          errors;

  function new();
    foreach (fb_model[i]) fb_model[i] = '0;
    src_x  = 0;
    src_y  = 0;
    dst_w  = 7'd64;
    dst_h  = 7'd64;
    spr_w  = 7'd64;
    spr_h  = 7'd64;
    ofs_x  = '0;
    ofs_y  = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      cab_pkg::CFG_DEST_WIDTH:    dst_w = val[6:0];
      cab_pkg::CFG_DEST_HEIGHT:   dst_h = val[6:0];
      cab_pkg::CFG_SPRITE_WIDTH:  spr_w = val[6:0];
      cab_pkg::CFG_SPRITE_HEIGHT: spr_h = val[6:0];
      cab_pkg::CFG_OFFSET_X:      ofs_x = val;
      cab_pkg::CFG_OFFSET_Y:      ofs_y = val;
      default: ;
    endcase
  endfunction

  function int unsigned mix_chan(int unsigned s, int unsigned d, int unsigned a);
    return (s * a + d * (255 - a)) / 255;
  endfunction

  // work out the result beat of one accepted command
  function void note_command(logic [1:0] cmd, logic [11:0] addr,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    blit_beat_t  exp_beat;
    int unsigned dw, dh, sw, sh, idx;
    int          dx, dy;
    bit          row_end, last;
    logic [31:0] word;
    exp_beat = '0;
    if (cmd == cab_pkg::CMD_LOAD) begin
      fb_model[addr] = {a, b, g, r};
      exp_beat.status = cab_pkg::ST_LOADED;
    end else if (cmd != cab_pkg::CMD_BLIT) begin
      // the unused code reads too
      word = fb_model[addr];
      exp_beat.status = cab_pkg::ST_READ;
      {exp_beat.alpha, exp_beat.blue, exp_beat.green, exp_beat.red} = word;
    end else begin
      // saturate sizes; a sprite dimension is at least one
      dw = (dst_w > cab_pkg::MAX_WIDTH) ? cab_pkg::MAX_WIDTH : dst_w;
      dh = (dst_h > cab_pkg::MAX_HEIGHT) ? cab_pkg::MAX_HEIGHT : dst_h;
      sw = (spr_w == 0) ? 1 : (spr_w > cab_pkg::MAX_WIDTH) ? cab_pkg::MAX_WIDTH : spr_w;
      sh = (spr_h == 0) ? 1 : (spr_h > cab_pkg::MAX_HEIGHT) ? cab_pkg::MAX_HEIGHT : spr_h;
      dx = int'(src_x) + int'($signed(ofs_x));
      dy = int'(src_y) + int'($signed(ofs_y));
      row_end = (src_x + 1 >= sw);
      last = row_end && (src_y + 1 >= sh);
      if (dx < 0 || dy < 0 || dx >= int'(dw) || dy >= int'(dh)) begin
        exp_beat.status = cab_pkg::ST_CLIPPED;
      end else if (a == 8'd0) begin
        exp_beat.status = cab_pkg::ST_SKIPPED;
      end else begin
        idx = dy * cab_pkg::MAX_WIDTH + dx;
        if (a == cab_pkg::ALPHA_OPAQUE) begin
          word = {cab_pkg::ALPHA_OPAQUE, b, g, r};
        end else begin
          // source-over blend per color channel, stored alpha is opaque
          word = {cab_pkg::ALPHA_OPAQUE,
                  8'(mix_chan(b, fb_model[idx][23:16], a)),
                  8'(mix_chan(g, fb_model[idx][15:8], a)),
                  8'(mix_chan(r, fb_model[idx][7:0], a))};
        end
        fb_model[idx] = word;
        exp_beat.status = cab_pkg::ST_WRITTEN;
        {exp_beat.alpha, exp_beat.blue, exp_beat.green, exp_beat.red} = word;
        exp_beat.col = dx[5:0];
        exp_beat.row = dy[5:0];
      end
      exp_beat.last = last;
      // raster counters wrap at the sprite edges
      if (row_end) begin
        src_x = 0;
        src_y = (src_y + 1 >= sh) ? 0 : src_y + 1;
      end else begin
        src_x = src_x + 1;
      end
    end
    pending_beats.push_back(exp_beat);
  endfunction

  function void check_beat(blit_beat_t got);
    blit_beat_t want;
    if (pending_beats.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected result beat st=%0d rgba=%h_%h_%h_%h col=%0d row=%0d last=%b",
                 $time, got.status, got.red, got.green, got.blue, got.alpha,
                 got.col, got.row, got.last);
      return;
    end
    want = pending_beats.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t: mismatch expected st=%0d rgba=%h_%h_%h_%h col=%0d row=%0d last=%b, %s",
                 $time, want.status, want.red, want.green, want.blue, want.alpha,
                 want.col, want.row, want.last,
                 $sformatf("actual st=%0d rgba=%h_%h_%h_%h col=%0d row=%0d last=%b",
                           got.status, got.red, got.green, got.blue, got.alpha,
                           got.col, got.row, got.last));
    end
  endfunction
endclass

module tb_clipped_alpha_blit_core;
  import cab_pkg::*;

  localparam logic [1:0] CMD_READ_ALT = 2'd3;
  localparam int         QUIET_LIMIT  = 12000;
  localparam int         ITEM_TARGET  = 1400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [2:0]            cfg_idx_i = '0;
  logic [7:0]            cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  blit_checker chk;
  int          burst_left = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          rx_hold = 0;
  int          rx_tick = 0;

  clipped_alpha_blit_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls: modes of always ready, coin flips, sparse ready and long holds
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: begin
        m_axis_tready <= (rx_tick % 4 == 0);
        rx_tick++;
      end
      default: begin
        if (rx_hold != 0) begin
          m_axis_tready <= 1'b0;
          rx_hold--;
        end else begin
          m_axis_tready <= 1'b1;
          rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : 0;
        end
      end
    endcase
  end

  // monitor both streams at the rising edge, plus the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        chk.note_command(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[19:12],
                         s_axis_tdata[27:20], s_axis_tdata[35:28], s_axis_tdata[43:36]);
      if (m_axis_tvalid && m_axis_tready)
        chk.check_beat({m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                        m_axis_tdata[23:16], m_axis_tdata[31:24], m_axis_tdata[37:32],
                        m_axis_tdata[43:38], m_axis_tlast});
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one command beat, sent in bursts with random gaps
  task automatic push_item(input logic [1:0] cmd, input logic [11:0] addr,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, a, b, g, r, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  // drop valid and wait for every outstanding result, then let the pipe settle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (chk.pending_beats.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= 8'(val);
    chk.set_reg(idx, 8'(val));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_dest_span();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 127;
      2:       return $urandom_range(65, 126);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic int rand_offset();
    case ($urandom_range(0, 5))
      0:       return -128;
      1:       return 127;
      2:       return int'($urandom_range(0, 255)) - 128;
      default: return int'($urandom_range(0, 24)) - 8;
    endcase
  endfunction

  initial begin
    int phase;
    int dw_v, dh_v, sw_v, sh_v, ox_v, oy_v;
    int dw_e, dh_e, sw_e, sh_e, n, row, col;
    logic [7:0] a;

    chk = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // framebuffer clearing sweep holds tready low
    do @(posedge clk_i); while (!s_axis_tready);

    // directed: small sprite hanging off the left edge of a small destination
    write_reg(CFG_DEST_WIDTH, 4);
    write_reg(CFG_DEST_HEIGHT, 4);
    write_reg(CFG_SPRITE_WIDTH, 3);
    write_reg(CFG_SPRITE_HEIGHT, 2);
    write_reg(CFG_OFFSET_X, -1);
    write_reg(CFG_OFFSET_Y, 0);
    push_item(CMD_LOAD, 12'd0, 8'd10, 8'd20, 8'd30, 8'd40);
    push_item(CMD_LOAD, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(CMD_LOAD, 12'd1, 8'd200, 8'd100, 8'd50, 8'd0);
    push_item(CMD_READ, 12'hFFF, 8'd0, 8'd0, 8'd0, 8'd0);
    push_item(CMD_READ_ALT, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_item(CMD_READ, 12'd2, 8'd0, 8'd0, 8'd0, 8'd0);
    // row 0: clipped, opaque copy, blend; row 1: clipped, transparent, faint blend
    push_item(CMD_BLIT, 12'd0, 8'd1, 8'd2, 8'd3, 8'd128);
    push_item(CMD_BLIT, 12'd0, 8'd255, 8'd0, 8'd128, 8'd255);
    push_item(CMD_BLIT, 12'd0, 8'd0, 8'd255, 8'd1, 8'd128);
    push_item(CMD_BLIT, 12'd0, 8'd9, 8'd9, 8'd9, 8'd200);
    push_item(CMD_BLIT, 12'd0, 8'd77, 8'd66, 8'd55, 8'd0);
    push_item(CMD_BLIT, 12'd0, 8'd255, 8'd255, 8'd255, 8'd1);
    push_item(CMD_READ, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_item(CMD_READ, 12'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    push_item(CMD_READ, 12'd65, 8'd0, 8'd0, 8'd0, 8'd0);
    // leave the counters mid-sprite so the next shrink wraps them
    push_item(CMD_BLIT, 12'd0, 8'd5, 8'd6, 8'd7, 8'd255);
    push_item(CMD_BLIT, 12'd0, 8'd40, 8'd50, 8'd60, 8'd254);
    push_item(CMD_LOAD, 12'hFFF, 8'd0, 8'd0, 8'd0, 8'd0);
    push_item(CMD_READ_ALT, 12'hFFF, 8'd0, 8'd0, 8'd0, 8'd0);

    dw_v = 4; dh_v = 4; sw_v = 3; sh_v = 2; ox_v = -1; oy_v = 0;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      // settings: fixed corner cases first, random afterwards
      if (phase < 5 || $urandom_range(0, 4) < 3) begin
        case (phase)
          0: begin dw_v = 0;   dh_v = 64;  sw_v = 2;   sh_v = 2;  ox_v = 0;    oy_v = 0;    end
          1: begin dw_v = 127; dh_v = 127; sw_v = 1;   sh_v = 1;  ox_v = 127;  oy_v = -128; end
          2: begin dw_v = 64;  dh_v = 1;   sw_v = 127; sh_v = 1;  ox_v = -1;   oy_v = 0;    end
          3: begin dw_v = 1;   dh_v = 1;   sw_v = 0;   sh_v = 0;  ox_v = 0;    oy_v = 0;    end
          4: begin dw_v = 64;  dh_v = 64;  sw_v = 1;   sh_v = 64; ox_v = 63;   oy_v = -1;   end
          default: begin
            if ($urandom_range(0, 1)) dw_v = rand_dest_span();
            if ($urandom_range(0, 1)) dh_v = rand_dest_span();
            if ($urandom_range(0, 4) == 0) begin
              // one long sprite dimension, the other thin
              n = ($urandom_range(0, 1)) ? 64 : $urandom_range(33, 127);
              if ($urandom_range(0, 1)) begin
                sw_v = n;
                sh_v = $urandom_range(0, 2);
              end else begin
                sh_v = n;
                sw_v = $urandom_range(0, 2);
              end
            end else begin
              sw_v = $urandom_range(0, 8);
              sh_v = $urandom_range(0, 8);
            end
            if ($urandom_range(0, 1)) ox_v = rand_offset();
            if ($urandom_range(0, 1)) oy_v = rand_offset();
          end
        endcase
        drain_results();
        write_reg(CFG_DEST_WIDTH, dw_v);
        write_reg(CFG_DEST_HEIGHT, dh_v);
        write_reg(CFG_SPRITE_WIDTH, sw_v);
        write_reg(CFG_SPRITE_HEIGHT, sh_v);
        write_reg(CFG_OFFSET_X, ox_v);
        write_reg(CFG_OFFSET_Y, oy_v);
      end
      dw_e = (dw_v > MAX_WIDTH) ? MAX_WIDTH : dw_v;
      dh_e = (dh_v > MAX_HEIGHT) ? MAX_HEIGHT : dh_v;
      sw_e = (sw_v == 0) ? 1 : (sw_v > MAX_WIDTH) ? MAX_WIDTH : sw_v;
      sh_e = (sh_v == 0) ? 1 : (sh_v > MAX_HEIGHT) ? MAX_HEIGHT : sh_v;

      if (phase < 5 || $urandom_range(0, 9) < 7) begin
        // preload some destination words, blit one sprite's count of pixels, read some back
        if (dw_e > 0 && dh_e > 0) begin
          n = $urandom_range(0, 6);
          repeat (n) begin
            row = $urandom_range(0, dh_e - 1);
            col = $urandom_range(0, dw_e - 1);
            push_item(CMD_LOAD, 12'(row * MAX_WIDTH + col), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
          end
        end
        repeat (sw_e * sh_e) begin
          case ($urandom_range(0, 3))
            0:       a = 8'd0;
            1:       a = ALPHA_OPAQUE;
            default: a = 8'($urandom_range(1, 254));
          endcase
          push_item(CMD_BLIT, 12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), a);
        end
        if (dw_e > 0 && dh_e > 0) begin
          n = $urandom_range(0, 6);
          repeat (n) begin
            row = $urandom_range(0, dh_e - 1);
            col = $urandom_range(0, dw_e - 1);
            push_item(($urandom_range(0, 3) == 0) ? CMD_READ_ALT : CMD_READ,
                      12'(row * MAX_WIDTH + col), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
          end
        end
      end else begin
        // noise: any command, any address, partial sprites
        n = $urandom_range(5, 30);
        repeat (n)
          push_item(2'($urandom_range(0, 3)), 12'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      end
      phase++;
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (chk.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== clipped_alpha_blit_core.f =====
rtl/core/cab_pkg.sv
rtl/core/cab_ram.sv
rtl/core/clipped_alpha_blit_core.sv
sim/tb_clipped_alpha_blit_core.sv
